// File: design/itrm_pkg.sv
// Shared types and constants for the traffic rate meter.
package itrm_pkg;
	localparam logic [2:0] OP_RD_BYTES = 3'd0;
	localparam logic [2:0] OP_RD_MSG   = 3'd1;
	localparam logic [2:0] OP_WR_BYTES = 3'd2;
	localparam logic [2:0] OP_WR_MSG   = 3'd3;
	localparam logic [2:0] OP_UPDATE   = 3'd4;
	localparam logic [55:0] RATE_MAX   = 56'hFF_FFFF_FFFF_FFFF;
	localparam int unsigned RATE_SCALE = 256000;

	typedef struct packed {
		logic [2:0]  opcode;
		logic [2:0]  worker_slot;
		logic [31:0] amount;
		logic [47:0] current_time;
	} in_item_t;

	typedef struct packed {
		logic        side;
		logic [47:0] byte_total;
		logic [47:0] message_total;
		logic [55:0] byte_rate;
		logic [55:0] message_rate;
		logic [55:0] peak_byte_rate;
		logic [55:0] peak_message_rate;
		logic [47:0] latest_time;
		logic        rate_invalid;
		logic        last_of_run;
	} out_item_t;
endpackage

// File: design/itrm_divider.sv
// Restoring divider for rate = floor(delta*256000/iv), one quotient bit per cycle.
module itrm_divider (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [47:0] delta,
	input  logic [47:0] iv,
	output logic        done,
	output logic [55:0] rate
);
	import itrm_pkg::*;

	// numerator below 2^66; 66 quotient bits, saturate to 56
	localparam int NB = 66;
	logic [65:0] num_q;
	logic [48:0] rem_q;
	logic [65:0] quo_q;
	logic [6:0]  cnt_q;
	logic        busy_q;
	logic [47:0] iv_q;
	logic [48:0] trial;
	logic [48:0] diff;

	assign trial = {rem_q[47:0], num_q[65]};
	assign diff  = trial - {1'b0, iv_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 7'(NB);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 7'd1;
				if (cnt_q == 7'd1) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			// delta*256000 = delta*(2^18 - 2^13 + ... ) computed via one 48x18 multiply
			num_q <= 66'(delta) * 66'(RATE_SCALE);
			iv_q  <= iv;
			rem_q <= '0;
			quo_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[64:0], 1'b0};
			if (!diff[48]) begin
				rem_q <= diff;
				quo_q <= {quo_q[64:0], 1'b1};
			end else begin
				rem_q <= trial;
				quo_q <= {quo_q[64:0], 1'b0};
			end
		end
	end

	assign rate = (|quo_q[65:56]) ? RATE_MAX : quo_q[55:0];
endmodule

// File: design/itrm_front.sv
// Front end: input handshake, slot counter updates, single-entry queue of update transactions.
module itrm_front #(
	parameter int WORKERS = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  itrm_pkg::in_item_t in_data,
	output logic              upd_valid,
	input  logic              upd_take,
	output logic [47:0]       upd_time,
	output logic [47:0]       tot_rb,
	output logic [47:0]       tot_rm,
	output logic [47:0]       tot_wb,
	output logic [47:0]       tot_wm,
	output logic [47:0]       max_rt,
	output logic [47:0]       max_wt
);
	import itrm_pkg::*;

	localparam int SW = (WORKERS > 1) ? $clog2(WORKERS) : 1;

	logic [47:0] rb_q [WORKERS];
	logic [47:0] rm_q [WORKERS];
	logic [47:0] wb_q [WORKERS];
	logic [47:0] wm_q [WORKERS];
	logic [47:0] rt_q [WORKERS];
	logic [47:0] wt_q [WORKERS];
	// single-entry queue holding a pending update; increments wait behind it
	logic        pend_q;
	logic [47:0] ptime_q;
	// summing sweep over slots
	logic        sum_q;
	logic [SW:0] idx_q;
	logic [47:0] s_rb_q, s_rm_q, s_wb_q, s_wm_q, s_rt_q, s_wt_q;
	logic        ready_q;
	logic        acc;
	logic        in_range;
	logic [SW-1:0] ii;

	assign in_stall = pend_q;
	assign acc = in_valid && !pend_q;
	// seven bits so that WORKERS = 64 still compares correctly
	assign in_range = ({4'b0, in_data.worker_slot} < 7'(WORKERS));
	assign ii = idx_q[SW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < WORKERS; i++) begin
				rb_q[i] <= '0; rm_q[i] <= '0; wb_q[i] <= '0;
				wm_q[i] <= '0; rt_q[i] <= '0; wt_q[i] <= '0;
			end
			pend_q  <= 1'b0;
			sum_q   <= 1'b0;
			ready_q <= 1'b0;
			idx_q   <= '0;
		end else begin
			if (acc && in_data.opcode == OP_UPDATE) begin
				pend_q <= 1'b1;
				sum_q  <= 1'b1;
				idx_q  <= '0;
			end else if (acc && in_range) begin
				unique case (in_data.opcode)
					OP_RD_BYTES: begin
						rb_q[SW'(in_data.worker_slot)] <=
							rb_q[SW'(in_data.worker_slot)] + 48'(in_data.amount);
						rt_q[SW'(in_data.worker_slot)] <= in_data.current_time;
					end
					OP_RD_MSG: begin
						rm_q[SW'(in_data.worker_slot)] <= rm_q[SW'(in_data.worker_slot)] + 48'd1;
						rt_q[SW'(in_data.worker_slot)] <= in_data.current_time;
					end
					OP_WR_BYTES: begin
						wb_q[SW'(in_data.worker_slot)] <=
							wb_q[SW'(in_data.worker_slot)] + 48'(in_data.amount);
						wt_q[SW'(in_data.worker_slot)] <= in_data.current_time;
					end
					OP_WR_MSG: begin
						wm_q[SW'(in_data.worker_slot)] <= wm_q[SW'(in_data.worker_slot)] + 48'd1;
						wt_q[SW'(in_data.worker_slot)] <= in_data.current_time;
					end
					default: ;
				endcase
			end
			if (sum_q) begin
				idx_q <= idx_q + 1'b1;
				if (idx_q == (SW+1)'(WORKERS - 1)) begin
					sum_q   <= 1'b0;
					ready_q <= 1'b1;
				end
			end
			if (ready_q && upd_take) begin
				ready_q <= 1'b0;
				pend_q  <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc && in_data.opcode == OP_UPDATE) begin
			ptime_q <= in_data.current_time;
			s_rb_q <= '0; s_rm_q <= '0; s_wb_q <= '0; s_wm_q <= '0;
			s_rt_q <= '0; s_wt_q <= '0;
		end else if (sum_q) begin
			s_rb_q <= s_rb_q + rb_q[ii];
			s_rm_q <= s_rm_q + rm_q[ii];
			s_wb_q <= s_wb_q + wb_q[ii];
			s_wm_q <= s_wm_q + wm_q[ii];
			if (rt_q[ii] > s_rt_q) s_rt_q <= rt_q[ii];
			if (wt_q[ii] > s_wt_q) s_wt_q <= wt_q[ii];
		end
	end

	assign upd_valid = ready_q;
	assign upd_time  = ptime_q;
	assign tot_rb = s_rb_q;
	assign tot_rm = s_rm_q;
	assign tot_wb = s_wb_q;
	assign tot_wm = s_wm_q;
	assign max_rt = s_rt_q;
	assign max_wt = s_wt_q;
endmodule

// File: design/itrm_back.sv
// Back end: rate computation, peaks, and result output register.
module itrm_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               upd_valid,
	output logic               upd_take,
	input  logic [47:0]        upd_time,
	input  logic [47:0]        tot_rb,
	input  logic [47:0]        tot_rm,
	input  logic [47:0]        tot_wb,
	input  logic [47:0]        tot_wm,
	input  logic [47:0]        max_rt,
	input  logic [47:0]        max_wt,
	output logic               out_valid,
	input  logic               out_stall,
	output itrm_pkg::out_item_t out_data
);
	import itrm_pkg::*;

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_DIV  = 5'b00010,
		ST_WAIT = 5'b00100,
		ST_RD   = 5'b01000,
		ST_WR   = 5'b10000
	} st_t;

	st_t st_q;
	logic [47:0] prev_q [4];
	logic [47:0] prev_time_q;
	logic [55:0] peak_q [4];
	logic [55:0] rate_q [4];
	logic [47:0] tot_q  [4];
	logic [47:0] grt_q, gwt_q;
	logic        inv_q;
	logic [1:0]  k_q;
	logic [47:0] iv_q;
	logic        div_start;
	logic        div_done;
	logic [55:0] div_rate;
	logic [47:0] iv;
	logic [47:0] dl;

	assign iv = upd_time - prev_time_q;
	assign dl = tot_q[k_q] - prev_q[k_q];
	assign upd_take = (st_q == ST_IDLE) && upd_valid;
	assign div_start = (st_q == ST_DIV);

	itrm_divider u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start),
		.delta(dl), .iv(iv_q), .done(div_done), .rate(div_rate)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			prev_time_q <= '0;
			grt_q <= '0;
			gwt_q <= '0;
			k_q <= '0;
			iv_q <= '0;
			inv_q <= 1'b0;
			for (int i = 0; i < 4; i++) begin
				prev_q[i] <= '0;
				peak_q[i] <= '0;
				rate_q[i] <= '0;
				tot_q[i]  <= '0;
			end
		end else begin
			unique case (st_q)
				ST_IDLE: if (upd_valid) begin
					tot_q[0] <= tot_rb; tot_q[1] <= tot_rm;
					tot_q[2] <= tot_wb; tot_q[3] <= tot_wm;
					if (max_rt > grt_q) grt_q <= max_rt;
					if (max_wt > gwt_q) gwt_q <= max_wt;
					iv_q <= iv;
					inv_q <= (iv == '0) || iv[47];
					prev_time_q <= upd_time;
					k_q <= '0;
					if ((iv == '0) || iv[47]) begin
						for (int i = 0; i < 4; i++) rate_q[i] <= RATE_MAX;
						st_q <= ST_RD;
					end else begin
						st_q <= ST_DIV;
					end
				end
				ST_DIV: st_q <= ST_WAIT;
				ST_WAIT: if (div_done) begin
					rate_q[k_q] <= div_rate;
					if (div_rate > peak_q[k_q]) peak_q[k_q] <= div_rate;
					k_q <= k_q + 2'd1;
					st_q <= (k_q == 2'd3) ? ST_RD : ST_DIV;
				end
				ST_RD: if (!out_stall) begin
					st_q <= ST_WR;
				end
				ST_WR: if (!out_stall) begin
					for (int i = 0; i < 4; i++) prev_q[i] <= tot_q[i];
					st_q <= ST_IDLE;
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	always_comb begin
		out_valid = (st_q == ST_RD) || (st_q == ST_WR);
		out_data.side = (st_q == ST_WR);
		out_data.last_of_run = (st_q == ST_WR);
		out_data.rate_invalid = inv_q;
		if (st_q == ST_WR) begin
			out_data.byte_total = tot_q[2];
			out_data.message_total = tot_q[3];
			out_data.byte_rate = rate_q[2];
			out_data.message_rate = rate_q[3];
			out_data.peak_byte_rate = peak_q[2];
			out_data.peak_message_rate = peak_q[3];
			out_data.latest_time = gwt_q;
		end else begin
			out_data.byte_total = tot_q[0];
			out_data.message_total = tot_q[1];
			out_data.byte_rate = rate_q[0];
			out_data.message_rate = rate_q[1];
			out_data.peak_byte_rate = peak_q[0];
			out_data.peak_message_rate = peak_q[1];
			out_data.latest_time = grt_q;
		end
	end
endmodule

// File: design/io_traffic_rate_meter.sv
// Top level of the per-worker traffic counter and rate meter.
//
//  channel | valid     | stall     | payload
//  input   | in_valid  | in_stall  | in_data  (itrm_pkg::in_item_t)
//  output  | out_valid | out_stall | out_data (itrm_pkg::out_item_t)
//
// Increment transactions are accepted back to back while no update is pending.
// An update transaction stalls the input while the slots are swept and until
// the back end takes the sums; the stall lasts longer while the back end still
// works on the previous update. Unless the interval is zero or negative, which
// saturates every rate, the back end runs four serial divisions (start,
// 66 quotient bits, done) on one shared divider, then presents the read and
// write results. Reset clears the slot counters and time stamps, previous totals and peaks.
module io_traffic_rate_meter #(
	parameter int WORKERS = 8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  itrm_pkg::in_item_t  in_data,
	output logic               out_valid,
	input  logic               out_stall,
	output itrm_pkg::out_item_t out_data
);
	import itrm_pkg::*;

	logic        upd_valid, upd_take;
	logic [47:0] upd_time, tot_rb, tot_rm, tot_wb, tot_wm, max_rt, max_wt;

	itrm_front #(.WORKERS(WORKERS)) u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.upd_valid(upd_valid), .upd_take(upd_take), .upd_time(upd_time),
		.tot_rb(tot_rb), .tot_rm(tot_rm), .tot_wb(tot_wb), .tot_wm(tot_wm),
		.max_rt(max_rt), .max_wt(max_wt)
	);

	// back end: divisions, peaks, result register
	itrm_back u_back (
		.clk(clk), .arst_n(arst_n),
		.upd_valid(upd_valid), .upd_take(upd_take), .upd_time(upd_time),
		.tot_rb(tot_rb), .tot_rm(tot_rm), .tot_wb(tot_wb), .tot_wm(tot_wm),
		.max_rt(max_rt), .max_wt(max_wt),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
	);
endmodule

// File: test/io_traffic_rate_meter_chk.sv
// Transaction checker for the traffic rate meter: predicts update results and compares them.
module io_traffic_rate_meter_chk (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                in_stall,
	input  itrm_pkg::in_item_t  in_data,
	input  logic                out_valid,
	input  logic                out_stall,
	input  itrm_pkg::out_item_t out_data,
	output int                  fail_count,
	output int                  pending
);
	import itrm_pkg::*;

	localparam int NSLOT = 8;

	logic [47:0] rd_bytes [NSLOT];
	logic [47:0] wr_bytes [NSLOT];
	logic [47:0] rd_msgs [NSLOT];
	logic [47:0] wr_msgs [NSLOT];
	logic [47:0] rd_stamp [NSLOT];
	logic [47:0] wr_stamp [NSLOT];
	logic [47:0] last_rd_time, last_wr_time, prev_update;
	logic [47:0] prev_tot [4];
	logic [55:0] peak [4];
	out_item_t meter_q[$];

	assign pending = meter_q.size();

	// floor(delta * 256000 / iv), saturated to 56 bits
	function automatic logic [55:0] per_second(logic [47:0] delta, logic [47:0] iv);
		logic [127:0] full;
		full = ({80'd0, delta} * 128'd256000) / {80'd0, iv};
		if (full > {72'd0, RATE_MAX})
			return RATE_MAX;
		return full[55:0];
	endfunction

	task automatic sample_update(in_item_t it);
		logic [47:0] tot [4];
		logic [55:0] rate [4];
		logic [47:0] rt, wt, iv;
		logic bad;
		out_item_t r;
		tot = '{default: '0};
		rt = last_rd_time;
		wt = last_wr_time;
		for (int i = 0; i < NSLOT; i++) begin
			tot[0] += rd_bytes[i];
			tot[1] += rd_msgs[i];
			tot[2] += wr_bytes[i];
			tot[3] += wr_msgs[i];
			if (rd_stamp[i] > rt) rt = rd_stamp[i];
			if (wr_stamp[i] > wt) wt = wr_stamp[i];
		end
		last_rd_time = rt;
		last_wr_time = wt;
		iv = it.current_time - prev_update;
		bad = (iv == 0) || iv[47];
		for (int k = 0; k < 4; k++) begin
			if (bad) begin
				rate[k] = RATE_MAX;
			end else begin
				rate[k] = per_second(tot[k] - prev_tot[k], iv);
				if (rate[k] > peak[k]) peak[k] = rate[k];
			end
			prev_tot[k] = tot[k];
		end
		prev_update = it.current_time;
		r = '{side: 1'b0, byte_total: tot[0], message_total: tot[1], byte_rate: rate[0],
			message_rate: rate[1], peak_byte_rate: peak[0], peak_message_rate: peak[1],
			latest_time: rt, rate_invalid: bad, last_of_run: 1'b0};
		meter_q.push_back(r);
		r = '{side: 1'b1, byte_total: tot[2], message_total: tot[3], byte_rate: rate[2],
			message_rate: rate[3], peak_byte_rate: peak[2], peak_message_rate: peak[3],
			latest_time: wt, rate_invalid: bad, last_of_run: 1'b1};
		meter_q.push_back(r);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NSLOT; i++) begin
				rd_bytes[i] = '0; wr_bytes[i] = '0; rd_msgs[i] = '0;
				wr_msgs[i] = '0; rd_stamp[i] = '0; wr_stamp[i] = '0;
			end
			for (int k = 0; k < 4; k++) begin
				prev_tot[k] = '0; peak[k] = '0;
			end
			last_rd_time = '0; last_wr_time = '0; prev_update = '0;
			fail_count = 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (meter_q.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("unexpected result %p", out_data);
				end else begin
					out_item_t e;
					e = meter_q.pop_front();
					if (e !== out_data) begin
						fail_count++;
						if (fail_count <= 10)
							$display("result differs: expected %p got %p", e, out_data);
					end
				end
			end
			if (in_valid && !in_stall) begin
				case (in_data.opcode)
				OP_RD_BYTES: begin
					rd_bytes[in_data.worker_slot] += in_data.amount;
					rd_stamp[in_data.worker_slot] = in_data.current_time;
				end
				OP_RD_MSG: begin
					rd_msgs[in_data.worker_slot] += 1;
					rd_stamp[in_data.worker_slot] = in_data.current_time;
				end
				OP_WR_BYTES: begin
					wr_bytes[in_data.worker_slot] += in_data.amount;
					wr_stamp[in_data.worker_slot] = in_data.current_time;
				end
				OP_WR_MSG: begin
					wr_msgs[in_data.worker_slot] += 1;
					wr_stamp[in_data.worker_slot] = in_data.current_time;
				end
				OP_UPDATE: sample_update(in_data);
				default: ;
				endcase
			end
		end
	end

	final begin
		if (meter_q.size() != 0)
			$display("%0d results never arrived", meter_q.size());
	end
endmodule

// File: test/io_traffic_rate_meter_tb.sv
// Stimulus and verdict for the traffic rate meter.
module io_traffic_rate_meter_tb;
	import itrm_pkg::*;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	in_item_t in_data = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	out_item_t out_data;
	int fail_count;
	int pending;
	bit calm;        // no idling on either side while set
	logic [47:0] clock_ms = 48'd1000;

	always #5 clk = ~clk;

	io_traffic_rate_meter uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
	);

	io_traffic_rate_meter_chk chk (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.fail_count(fail_count), .pending(pending)
	);

	// Receiver stalls about 9% of cycles, never during the calm stretch.
	always @(negedge clk)
		out_stall <= !calm && ($urandom_range(99) < 9);

	// Present one transaction and hold it until accepted; a random idle gap may
	// go first outside the calm stretch, else valid stays high across back-to-back transactions.
	task automatic send(logic [2:0] op, logic [2:0] slot, logic [31:0] amt,
			logic [47:0] t);
		while (!calm && $urandom_range(99) < 9) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_data <= '{opcode: op, worker_slot: slot, amount: amt, current_time: t};
		@(posedge clk);
		while (in_stall) @(posedge clk);
		@(negedge clk);
	endtask

	// Mostly increments with a mostly rising clock, occasional updates and ignored opcodes.
	task automatic traffic(int n);
		logic [2:0] op;
		logic [31:0] amt;
		for (int i = 0; i < n; i++) begin
			op = 3'($urandom_range(3));
			if ($urandom_range(99) < 6) op = OP_UPDATE;
			else if ($urandom_range(99) < 3) op = 3'($urandom_range(7, 5));
			amt = ($urandom_range(9) == 0) ? $urandom : $urandom_range(1500);
			if ($urandom_range(49) == 0)
				clock_ms = 48'({$urandom, $urandom});   // jumps, may go backwards
			else
				clock_ms = clock_ms + 48'($urandom_range(400));
			send(op, 3'($urandom), amt, clock_ms);
		end
	endtask

	initial begin
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		calm = 1'b1;
		// Directed: every opcode, field extremes, zero and negative interval,
		// ignored opcodes, tiny interval.
		send(OP_UPDATE, 3'd0, 32'd0, 48'd0);                 // zero interval
		send(OP_RD_BYTES, 3'd0, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF);
		send(OP_RD_MSG, 3'd7, 32'd0, 48'd5);
		send(OP_WR_BYTES, 3'd7, 32'hFFFF_FFFF, 48'd7);
		send(OP_WR_MSG, 3'd0, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF);
		send(3'd5, 3'd3, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF);
		send(3'd6, 3'd3, 32'd1, 48'd1);
		send(3'd7, 3'd3, 32'd1, 48'd1);
		send(OP_UPDATE, 3'd7, 32'hFFFF_FFFF, 48'd1);          // tiny interval, large rate
		send(OP_UPDATE, 3'd0, 32'd0, 48'd1);                  // zero interval again
		send(OP_UPDATE, 3'd0, 32'd0, 48'h8000_0000_0001);     // negative interval
		send(OP_RD_BYTES, 3'd3, 32'd12345, 48'h8000_0000_0100);
		send(OP_WR_BYTES, 3'd4, 32'd777, 48'h8000_0000_0200);
		send(OP_UPDATE, 3'd0, 32'd0, 48'h8000_0000_03E8);
		send(OP_UPDATE, 3'd0, 32'd0, 48'hFFFF_FFFF_FFFF);     // large positive gap
		clock_ms = 48'd2000;
		send(OP_UPDATE, 3'd0, 32'd0, clock_ms);
		// Calm stretch of random traffic with no idling on either side.
		traffic(300);
		calm = 1'b0;
		traffic(800);
		// Sender holds off until every expected result has come.
		in_valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		traffic(830);
		in_valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (20) @(negedge clk);
		if (fail_count == 0)
			$display("io_traffic_rate_meter: match");
		else
			$display("io_traffic_rate_meter: mismatch");
		$finish;
	end

	// ends the run as a mismatch if it overruns the worst case, with stalls and margin
	initial begin
		#40000000;
		$display("io_traffic_rate_meter: mismatch");
		$finish;
	end
endmodule

// File: sim.f
design/itrm_pkg.sv
design/itrm_divider.sv
design/itrm_front.sv
design/itrm_back.sv
design/io_traffic_rate_meter.sv
test/io_traffic_rate_meter_chk.sv
test/io_traffic_rate_meter_tb.sv
